@@ rtl/core/quic_packet_pacer_defines.svh @@
// Assertion helpers used by the pacer top module.
`ifndef QUIC_PACKET_PACER_DEFINES_SVH
`define QUIC_PACKET_PACER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QPP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pacer check failed");

// Next-cycle implication, checked outside reset.
`define QPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pacer check failed");

`endif

@@ rtl/core/qpp_pkg.sv @@
// ----------------------------------------------------------------------------
// qpp_pkg
// Types and constants shared by the packet pacer modules.
// ----------------------------------------------------------------------------
package qpp_pkg;

    localparam logic [1:0]  BURST_REFILL   = 2'd2;
    localparam logic [51:0] USEC_PER_SEC   = 52'd1000000;
    localparam logic [31:0] MAX_DELAY      = 32'hFFFF_FFFF;
    localparam logic [63:0] MIN_BW         = 64'd150000;
    localparam logic [63:0] EARLY_SLACK_US = 64'd1000;
    localparam logic [31:0] LUMPY_TWO_CWND = 32'd9600;
    localparam logic [31:0] RTT_RESET      = 32'd250000;
    localparam logic [63:0] RATE_DIVISOR   = 64'd10;

    localparam logic CFG_BBR_MODE    = 1'b0;
    localparam logic CFG_INITIAL_RTT = 1'b1;

    localparam logic FUNC_SENT  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic        func;
        logic [61:0] now_us;
        logic [31:0] cwnd_bytes;
        logic [31:0] srtt_us;
        logic [31:0] inflight_bytes;
        logic [15:0] packet_bytes;
        logic [39:0] cc_pacing_rate;
        logic [39:0] cc_bw_estimate;
        logic        slow_start;
        logic        timer_armed;
    } in_item_t;

    typedef struct packed {
        logic        write_ok;
        logic        arm_timer;
        logic [61:0] timer_deadline_us;
    } out_item_t;

    typedef enum logic [1:0] {
        DIV_CPR,
        DIV_DLY
    } div_sel_t;

    typedef enum logic [1:0] {
        RATE_CC,
        RATE_DOUBLE,
        RATE_TEN
    } rate_sel_t;

    typedef struct packed {
        logic      idle;
        logic      load_item;
        logic      calc_prod;
        logic      prod_pkt;
        logic      div_start;
        div_sel_t  div_sel;
        logic      ten_start;
        logic      cap_cpr;
        logic      set_rate;
        rate_sel_t rate_sel;
        logic      set_delay;
        logic      delay_max;
        logic      update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic func;
        logic burst_nonzero;
        logic bbr;
        logic slow_start;
        logic rate_zero;
        logic div_done;
        logic div_busy;
        logic ten_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/core/qpp_div.sv @@
// ----------------------------------------------------------------------------
// qpp_div
// Shared 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qpp_div
    import qpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dvs_reg;
    logic [64:0] trial;
    logic [64:0] diff;

    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_reg <= diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/qpp_datapath.sv @@
// ----------------------------------------------------------------------------
// qpp_datapath
// Item and token registers, rate and delay arithmetic, result register.
// ----------------------------------------------------------------------------
module qpp_datapath
    import qpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  stat,
    input  in_item_t    in_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    in_item_t    item_reg;
    logic        bbr_reg;
    logic [31:0] init_rtt_reg;
    logic [1:0]  burst_reg;
    logic [1:0]  lumpy_reg;
    logic        rlim_reg;
    logic [63:0] ideal_reg;
    logic [51:0] prod_reg;
    logic [63:0] cpr_reg;
    logic [63:0] rate_reg;
    logic [31:0] delay_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;
    logic [63:0] ten_n_reg;
    logic [63:0] ten_q_reg;
    logic [2:0]  ten_cnt_reg;
    logic        ten_busy_reg;
    logic        ten_done_reg;

    logic [31:0] eff_rtt;
    logic [51:0] mult_a;
    logic [63:0] div_a;
    logic [63:0] div_b;
    logic        div_busy;
    logic        div_done;
    logic [63:0] div_q;
    logic [63:0] next_rate;

    logic [1:0]  burst_next;
    logic [1:0]  lumpy_next;
    logic        rlim_next;
    logic [63:0] ideal_next;
    out_item_t   result;
    logic [1:0]  lumpy_fill;
    logic [63:0] bw;
    logic [63:0] sum_a;
    logic [63:0] sum_b;
    logic [1:0]  qburst;
    logic        inflight_zero;

    always_comb
    begin
        if (item_reg.srtt_us != 32'd0)
            eff_rtt = item_reg.srtt_us;
        else if (init_rtt_reg != 32'd0)
            eff_rtt = init_rtt_reg;
        else
            eff_rtt = 32'd1;

        mult_a = cmd.prod_pkt ? {36'd0, item_reg.packet_bytes} : {20'd0, item_reg.cwnd_bytes};

        case (cmd.div_sel)
            DIV_CPR:
            begin
                div_a = {12'd0, prod_reg};
                div_b = {32'd0, eff_rtt};
            end
            DIV_DLY:
            begin
                div_a = {12'd0, prod_reg};
                div_b = rate_reg;
            end
            default:
            begin
                div_a = {12'd0, prod_reg};
                div_b = 64'd1;
            end
        endcase

        case (cmd.rate_sel)
            RATE_CC:     next_rate = {24'd0, item_reg.cc_pacing_rate};
            RATE_DOUBLE: next_rate = {cpr_reg[62:0], 1'b0};
            RATE_TEN:    next_rate = ten_q_reg;
            default:     next_rate = ten_q_reg;
        endcase
    end

    qpp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Division of twelve times the window rate by ten, as a shift-and-add
    // estimate of n * 0.8 / 8 followed by a one-step remainder correction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ten_busy_reg <= 1'b0;
            ten_done_reg <= 1'b0;
            ten_cnt_reg  <= '0;
        end
        else
        begin
            ten_done_reg <= 1'b0;
            if (cmd.ten_start)
            begin
                ten_busy_reg <= 1'b1;
                ten_cnt_reg  <= '0;
            end
            else if (ten_busy_reg)
            begin
                ten_cnt_reg <= ten_cnt_reg + 3'd1;
                if (ten_cnt_reg == 3'd7)
                begin
                    ten_busy_reg <= 1'b0;
                    ten_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ten_start)
            ten_n_reg <= (cpr_reg << 3) + (cpr_reg << 2);
        else if (ten_busy_reg)
        begin
            case (ten_cnt_reg)
                3'd0:    ten_q_reg <= (ten_n_reg >> 1) + (ten_n_reg >> 2);
                3'd1:    ten_q_reg <= ten_q_reg + (ten_q_reg >> 4);
                3'd2:    ten_q_reg <= ten_q_reg + (ten_q_reg >> 8);
                3'd3:    ten_q_reg <= ten_q_reg + (ten_q_reg >> 16);
                3'd4:    ten_q_reg <= ten_q_reg + (ten_q_reg >> 32);
                3'd5:    ten_q_reg <= ten_q_reg >> 3;
                3'd6:    ten_n_reg <= ten_n_reg - ((ten_q_reg << 3) + (ten_q_reg << 1));
                default: ten_q_reg <= ten_q_reg + {63'd0, (ten_n_reg >= RATE_DIVISOR)};
            endcase
        end
    end

    always_comb
    begin
        burst_next    = burst_reg;
        lumpy_next    = lumpy_reg;
        rlim_next     = rlim_reg;
        ideal_next    = ideal_reg;
        result        = '0;
        inflight_zero = (item_reg.inflight_bytes == 32'd0);
        qburst        = inflight_zero ? BURST_REFILL : burst_reg;
        bw            = bbr_reg ? {24'd0, item_reg.cc_bw_estimate} : cpr_reg;
        if (bw < MIN_BW || item_reg.cwnd_bytes < LUMPY_TWO_CWND)
            lumpy_fill = 2'd1;
        else
            lumpy_fill = 2'd2;
        sum_a = ideal_reg + {32'd0, delay_reg};
        sum_b = {2'b00, item_reg.now_us} + {32'd0, delay_reg};

        if (item_reg.func == FUNC_SENT)
        begin
            if (burst_reg != 2'd0)
            begin
                burst_next = burst_reg - 2'd1;
                rlim_next  = 1'b0;
            end
            else
            begin
                if (!rlim_reg || lumpy_reg == 2'd0)
                    lumpy_next = lumpy_fill - 2'd1;
                else
                    lumpy_next = lumpy_reg - 2'd1;
                if (rlim_reg || sum_a > sum_b)
                    ideal_next = sum_a;
                else
                    ideal_next = sum_b;
                rlim_next = ({1'b0, item_reg.inflight_bytes} + {17'd0, item_reg.packet_bytes})
                            < {1'b0, item_reg.cwnd_bytes};
            end
        end
        else
        begin
            burst_next = qburst;
            if (item_reg.timer_armed)
                result.write_ok = 1'b0;
            else if (item_reg.inflight_bytes >= item_reg.cwnd_bytes)
                result.write_ok = 1'b0;
            else if (qburst != 2'd0 || inflight_zero || lumpy_reg != 2'd0)
                result.write_ok = 1'b1;
            else if (ideal_reg > ({2'b00, item_reg.now_us} + EARLY_SLACK_US))
            begin
                result.arm_timer         = 1'b1;
                result.timer_deadline_us = ideal_reg[61:0];
            end
            else
                result.write_ok = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bbr_reg       <= 1'b0;
            init_rtt_reg  <= RTT_RESET;
            burst_reg     <= '0;
            lumpy_reg     <= '0;
            rlim_reg      <= 1'b0;
            ideal_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BBR_MODE:    bbr_reg      <= cfg_data[0];
                    CFG_INITIAL_RTT: init_rtt_reg <= cfg_data;
                    default:         bbr_reg      <= bbr_reg;
                endcase
            end
            if (cmd.update)
            begin
                burst_reg     <= burst_next;
                lumpy_reg     <= lumpy_next;
                rlim_reg      <= rlim_next;
                ideal_reg     <= ideal_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_data;
        if (cmd.calc_prod)
            prod_reg <= mult_a * USEC_PER_SEC;
        if (cmd.cap_cpr)
            cpr_reg <= div_q;
        if (cmd.set_rate)
            rate_reg <= next_rate;
        if (cmd.set_delay)
            delay_reg <= (cmd.delay_max || div_q[63:32] != 32'd0) ? MAX_DELAY : div_q[31:0];
        if (cmd.update)
            out_reg <= result;
    end

    assign stat.func          = item_reg.func;
    assign stat.burst_nonzero = (burst_reg != 2'd0);
    assign stat.bbr           = bbr_reg;
    assign stat.slow_start    = item_reg.slow_start;
    assign stat.rate_zero     = (rate_reg == 64'd0);
    assign stat.div_done      = div_done;
    assign stat.div_busy      = div_busy;
    assign stat.ten_done      = ten_done_reg;
    assign stat.out_free      = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ rtl/core/qpp_ctrl.sv @@
// ----------------------------------------------------------------------------
// qpp_ctrl
// Sequencer for one pacer item: rate, delay and state update steps.
// ----------------------------------------------------------------------------
module qpp_ctrl
    import qpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL_CWND,
        S_DIV_CPR,
        S_WAIT_CPR,
        S_RATE_SEL,
        S_WAIT_TEN,
        S_RATE_CHK,
        S_MUL_PKT,
        S_DIV_DLY,
        S_WAIT_DLY,
        S_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.func == FUNC_QUERY || stat.burst_nonzero)
                    state_next = S_UPDATE;
                else if (stat.bbr)
                begin
                    cmd.set_rate = 1'b1;
                    cmd.rate_sel = RATE_CC;
                    state_next   = S_RATE_CHK;
                end
                else
                    state_next = S_MUL_CWND;
            end
            S_MUL_CWND:
            begin
                cmd.calc_prod = 1'b1;
                state_next    = S_DIV_CPR;
            end
            S_DIV_CPR:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_CPR;
                state_next    = S_WAIT_CPR;
            end
            S_WAIT_CPR:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_cpr = 1'b1;
                    state_next  = S_RATE_SEL;
                end
            end
            S_RATE_SEL:
            begin
                if (stat.slow_start)
                begin
                    cmd.set_rate = 1'b1;
                    cmd.rate_sel = RATE_DOUBLE;
                    state_next   = S_RATE_CHK;
                end
                else
                begin
                    cmd.ten_start = 1'b1;
                    state_next    = S_WAIT_TEN;
                end
            end
            S_WAIT_TEN:
            begin
                if (stat.ten_done)
                begin
                    cmd.set_rate = 1'b1;
                    cmd.rate_sel = RATE_TEN;
                    state_next   = S_RATE_CHK;
                end
            end
            S_RATE_CHK:
            begin
                if (stat.rate_zero)
                begin
                    cmd.set_delay = 1'b1;
                    cmd.delay_max = 1'b1;
                    state_next    = S_UPDATE;
                end
                else
                    state_next = S_MUL_PKT;
            end
            S_MUL_PKT:
            begin
                cmd.calc_prod = 1'b1;
                cmd.prod_pkt  = 1'b1;
                state_next    = S_DIV_DLY;
            end
            S_DIV_DLY:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DLY;
                state_next    = S_WAIT_DLY;
            end
            S_WAIT_DLY:
            begin
                cmd.div_sel = DIV_DLY;
                if (stat.div_done)
                begin
                    cmd.set_delay = 1'b1;
                    state_next    = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (stat.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/quic_packet_pacer.sv @@
// ----------------------------------------------------------------------------
// quic_packet_pacer
// Packet pacer with burst and lumpy tokens and an ideal send time.
//
//   channel   signals                          payload
//   in        in_valid / in_ready              in_data   (in_item_t)
//   out       out_valid / out_ready            out_data  (out_item_t)
//   cfg       cfg_we, cfg_index                cfg_data  (32 bits)
//
// A query or a burst-token send passes through the dispatch and update states;
// the result is registered in the update state once the output is free. A paced
// send runs the shared divider for the window rate outside BBR mode and for the
// delay; outside BBR mode and slow start an 8-step divide by ten is added; a zero rate skips the delay division.
// Reset clears all tokens and the ideal send time; no clearing pass.
// A new beat is accepted while the previous result waits on out_ready.
// ----------------------------------------------------------------------------
`include "quic_packet_pacer_defines.svh"

module quic_packet_pacer
    import qpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    qpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    qpp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign in_ready = cmd.idle;

    `QPP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `QPP_ASSERT_NOW(a_no_accept_while_dividing, stat.div_busy, !in_ready)
    `QPP_ASSERT_NEXT(a_update_shows_result, cmd.update, out_valid)

endmodule

@@ tb/quic_packet_pacer_tb.sv @@
// ----------------------------------------------------------------------------
// quic_packet_pacer_tb
// Self-checking bench for the packet pacer. A table of directed beats covers
// reset behavior, field extremes, zero rate, delay saturation, full window and
// early send; random sent and query beats follow under several register
// settings. Every result beat is compared with a software copy of the pacer.
// ----------------------------------------------------------------------------
module quic_packet_pacer_tb;
    import qpp_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [61:0] M62 = {62{1'b1}};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    quic_packet_pacer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic        bbr_q;
    logic [31:0] init_rtt_q;
    logic [1:0]  burst_q;
    logic [1:0]  lumpy_q;
    logic        limited_q;
    logic [63:0] ideal_q;

    out_item_t pending_results[$];
    int        errors;
    int        cycles;

    typedef struct {
        in_item_t  beat;
        bit        has_expect;
        out_item_t want;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [63:0] window_rate(logic [31:0] cwnd, logic [31:0] srtt);
        logic [63:0] d;
        d = (srtt != 0) ? {32'd0, srtt} : {32'd0, init_rtt_q};
        if (d == 0)
        begin
            d = 1;
        end
        return ({32'd0, cwnd} * 64'd1000000) / d;
    endfunction

    function automatic out_item_t pacer_predict(in_item_t b);
        out_item_t   r;
        logic [63:0] rate;
        logic [63:0] delay;
        logic [63:0] q;
        logic [63:0] bw;
        logic [63:0] a;
        logic [63:0] c;
        r = '0;
        if (b.func == FUNC_SENT)
        begin
            if (burst_q > 0)
            begin
                burst_q--;
                limited_q = 1'b0;
            end
            else
            begin
                if (bbr_q)
                begin
                    rate = {24'd0, b.cc_pacing_rate};
                end
                else if (b.slow_start)
                begin
                    rate = window_rate(b.cwnd_bytes, b.srtt_us) * 2;
                end
                else
                begin
                    rate = window_rate(b.cwnd_bytes, b.srtt_us) * 12 / 10;
                end
                if (rate == 0)
                begin
                    delay = 64'hFFFF_FFFF;
                end
                else
                begin
                    delay = ({48'd0, b.packet_bytes} * 64'd1000000) / rate;
                    if (delay > 64'hFFFF_FFFF)
                    begin
                        delay = 64'hFFFF_FFFF;
                    end
                end
                if (!limited_q || lumpy_q == 0)
                begin
                    q = b.cwnd_bytes / 4800;
                    if (q < 1)
                    begin
                        q = 1;
                    end
                    if (q > 2)
                    begin
                        q = 2;
                    end
                    bw = bbr_q ? {24'd0, b.cc_bw_estimate}
                               : window_rate(b.cwnd_bytes, b.srtt_us);
                    if (bw < 150000)
                    begin
                        q = 1;
                    end
                    lumpy_q = q[1:0];
                end
                lumpy_q = lumpy_q - 2'd1;
                a = ideal_q + delay;
                c = {2'b00, b.now_us} + delay;
                ideal_q = (limited_q || a > c) ? a : c;
                limited_q = ({32'd0, b.inflight_bytes} + b.packet_bytes)
                            < {32'd0, b.cwnd_bytes};
            end
        end
        else
        begin
            if (b.inflight_bytes == 0)
            begin
                burst_q = BURST_REFILL;
            end
            if (b.timer_armed || b.inflight_bytes >= b.cwnd_bytes)
            begin
                r.write_ok = 1'b0;
            end
            else if (burst_q > 0 || b.inflight_bytes == 0 || lumpy_q > 0)
            begin
                r.write_ok = 1'b1;
            end
            else if (ideal_q > {2'b00, b.now_us} + 64'd1000)
            begin
                r.arm_timer = 1'b1;
                r.timer_deadline_us = ideal_q[61:0];
            end
            else
            begin
                r.write_ok = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic in_item_t random_beat(bit mostly_sent);
        in_item_t b;
        b = '0;
        b.func = mostly_sent ? ($urandom_range(0, 9) < 6 ? FUNC_SENT : FUNC_QUERY)
                             : 1'($urandom_range(0, 1));
        b.now_us = ($urandom_range(0, 19) == 0) ? 62'({$urandom, $urandom} & {2'b00, M62})
                                                 : 62'($urandom_range(0, 100000000));
        case ($urandom_range(0, 3))
            0: b.cwnd_bytes = $urandom;
            1: b.cwnd_bytes = $urandom_range(0, 12000);
            default: b.cwnd_bytes = $urandom_range(1000, 2000000);
        endcase
        case ($urandom_range(0, 3))
            0: b.srtt_us = $urandom;
            1: b.srtt_us = 0;
            default: b.srtt_us = $urandom_range(1, 500000);
        endcase
        b.inflight_bytes = $urandom_range(0, 3) == 0 ? 32'd0
                         : ($urandom_range(0, 5) == 0 ? $urandom
                                                      : $urandom_range(0, 2 * b.cwnd_bytes));
        b.packet_bytes = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1500));
        b.cc_pacing_rate = $urandom_range(0, 3) == 0 ? 40'({$urandom, $urandom})
                                                     : 40'($urandom_range(0, 20000000));
        b.cc_bw_estimate = $urandom_range(0, 3) == 0 ? 40'({$urandom, $urandom})
                                                     : 40'($urandom_range(0, 400000));
        b.slow_start = 1'($urandom_range(0, 1));
        b.timer_armed = ($urandom_range(0, 4) == 0);
        return b;
    endfunction

    task automatic send_beat(in_item_t b);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(pacer_predict(b));
    endtask

    task automatic idle_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        idle_input();
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BBR_MODE)
        begin
            bbr_q = val[0];
        end
        else
        begin
            init_rtt_q = val;
        end
    endtask

    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
            out_ready <= (stall == 0);
            if (stall != 0)
            begin
                repeat (stall) @(negedge clk);
                out_ready <= 1'b1;
            end
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat %h", out_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.write_ok !== want.write_ok)
                begin
                    $error("write_ok expected %0d actual %0d", want.write_ok, out_data.write_ok);
                    errors++;
                end
                if (out_data.arm_timer !== want.arm_timer)
                begin
                    $error("arm_timer expected %0d actual %0d",
                           want.arm_timer, out_data.arm_timer);
                    errors++;
                end
                if (out_data.timer_deadline_us !== want.timer_deadline_us)
                begin
                    $error("timer_deadline_us expected %0d actual %0d",
                           want.timer_deadline_us, out_data.timer_deadline_us);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic in_item_t mk(logic f, logic [61:0] now, logic [31:0] cwnd,
                                    logic [31:0] srtt, logic [31:0] infl,
                                    logic [15:0] pkt, logic [39:0] rate,
                                    logic [39:0] bw, logic ss, logic armed);
        in_item_t b;
        b = {f, now, cwnd, srtt, infl, pkt, rate, bw, ss, armed};
        return b;
    endfunction

    initial
    begin
        row_t      rows[$];
        row_t      r;
        out_item_t got;
        int        phase;
        int        n;
        errors    = 0;
        cycles    = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_BBR_MODE;
        cfg_data  = '0;
        bbr_q      = 1'b0;
        init_rtt_q = RTT_RESET;
        burst_q    = '0;
        lumpy_q    = '0;
        limited_q  = 1'b0;
        ideal_q    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        rows = '{
            '{mk(FUNC_QUERY, 0, 1000, 0, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 1'b0, 62'd0}},
            '{mk(FUNC_QUERY, 0, 1000, 0, 0, 0, 0, 0, 0, 1), 1, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_QUERY, 5, 100, 10, 100, 0, 0, 0, 0, 0), 1, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_SENT, 0, 100000, 100, 10, 1200, 0, 0, 0, 0), 1, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_SENT, 0, 100000, 100, 10, 1200, 0, 0, 1, 0), 1, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_SENT, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0), 0, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_SENT, M62, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 1, 1), 0, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_SENT, 7, 9600, 1, 5, 1500, 0, 0, 0, 0), 0, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_QUERY, 0, 9600, 1, 5, 0, 0, 0, 0, 0), 0, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_QUERY, M62, 9600, 1, 5, 0, 0, 0, 0, 0), 0, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_SENT, 3, 4000, 0, 10, 1000, 0, 0, 0, 0), 0, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_SENT, 3, 4000, 0, 10, 1000, 0, 0, 0, 0), 0, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_QUERY, 3, 4000, 0, 10, 0, 0, 0, 0, 0), 0, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_SENT, 10, 200000, 50000, 0, 65535, 0, 0, 1, 0), 0, '{1'b0, 1'b0, 62'd0}},
            '{mk(FUNC_QUERY, 10, 200000, 50000, 1, 0, 0, 0, 0, 0), 0, '{1'b0, 1'b0, 62'd0}}
        };
        foreach (rows[i])
        begin
            r = rows[i];
            send_beat(r.beat);
            if (r.has_expect)
            begin
                got = pending_results[pending_results.size() - 1];
                if (got !== r.want)
                begin
                    $error("directed row %0d expected %h predicted %h", i, r.want, got);
                    errors++;
                end
            end
        end
        drain_results();

        // Zero smoothed and initial RTT and the extremes of both registers.
        write_reg(CFG_INITIAL_RTT, 32'd0);
        send_beat(mk(FUNC_SENT, 1, 5000, 0, 10, 100, 0, 0, 0, 0));
        send_beat(mk(FUNC_SENT, 1, 5000, 0, 10, 100, 0, 0, 0, 0));
        send_beat(mk(FUNC_SENT, 1, 5000, 0, 10, 100, 0, 0, 1, 0));
        drain_results();
        write_reg(CFG_BBR_MODE, 1'b1);
        send_beat(mk(FUNC_SENT, 2, 20000, 5, 10, 1200, 0, 0, 0, 0));
        send_beat(mk(FUNC_SENT, 2, 20000, 5, 10, 1200, 1, 200000, 0, 0));
        send_beat(mk(FUNC_SENT, 2, 20000, 5, 10, 1200, 40'hFFFFFFFFFF, 149999, 0, 0));
        send_beat(mk(FUNC_QUERY, 2, 20000, 5, 10, 0, 0, 0, 0, 0));
        drain_results();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(CFG_BBR_MODE, 0); write_reg(CFG_INITIAL_RTT, 1); end
                1: begin write_reg(CFG_BBR_MODE, 1); write_reg(CFG_INITIAL_RTT, 32'hFFFFFFFF); end
                2: begin write_reg(CFG_BBR_MODE, 0); write_reg(CFG_INITIAL_RTT, $urandom); end
                3: begin write_reg(CFG_BBR_MODE, 1); write_reg(CFG_INITIAL_RTT, 250000); end
                4: begin write_reg(CFG_BBR_MODE, 0); write_reg(CFG_INITIAL_RTT, 32'hFFFFFFFF); end
                default: begin write_reg(CFG_BBR_MODE, 0); write_reg(CFG_INITIAL_RTT, 100000); end
            endcase
            for (n = 0; n < 290; n++)
            begin
                send_beat(random_beat(n % 3 != 0));
                if (n == 150)
                begin
                    idle_input();
                    while (pending_results.size() != 0)
                    begin
                        @(negedge clk);
                    end
                end
            end
            drain_results();
        end

        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
